// ===== design/b64_pkg.sv =====
// b64_pkg: types, codes and character tables shared by the Base64 codec modules.
// No dependencies.
package b64_pkg;

  // Kind of work carried from the front end to the back end
  typedef enum logic [1:0] {
    KIND_ENC = 2'd0,
    KIND_DEC = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  // One closed group, ready to be expanded into result transactions
  typedef struct packed {
    kind_t       kind;
    logic [23:0] bits;   // group, first item in the high bits
    logic [2:0]  nres;   // number of results, 1..4
    logic [2:0]  nval;   // encode: characters before padding, 2..4
    logic        last;   // group closes the message
  } job_t;

  localparam int JobWidth = $bits(job_t);

  localparam logic       MODE_ENC = 1'b0;
  localparam logic       MODE_DEC = 1'b1;
  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  // Sextet to character, standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Character to sextet; anything outside the alphabet gives zero
  function automatic logic [5:0] b64_sextet(input logic [7:0] c);
    logic [5:0] s;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s = 6'd62;
    end else if (c == 8'h2F) begin
      s = 6'd63;
    end else begin
      s = 6'd0;
    end
    return s;
  endfunction

endpackage

// ===== design/b64_front.sv =====
// b64_front: accepts input transactions, gathers groups and queues closed groups.
// Holds the mode register. Depends on b64_pkg.
module b64_front import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_in,
  input  logic       last_in,
  input  logic       queue_full,
  output logic       push,
  output job_t       job
);

  logic        mode;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pad_count;

  logic        accept;
  logic [23:0] bits_next;
  logic [1:0]  count_next;
  logic [1:0]  pad_next;
  logic [1:0]  pad_upd;
  logic [2:0]  enc_cnt;
  logic [5:0]  sextet;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign enc_cnt  = {1'b0, group_count} + 3'd1;
  assign sextet   = b64_sextet(data_in);

  // '=' counts only in the third and fourth places of a decode group
  assign pad_upd = (data_in == CHAR_PAD && group_count >= 2'd2 && pad_count < 2'd3)
                 ? pad_count + 2'd1 : pad_count;

  // Group closing and job build
  always_comb begin
    bits_next  = group_bits;
    count_next = group_count;
    pad_next   = pad_count;
    push       = 1'b0;
    job        = '0;
    job.last   = last_in;
    if (mode == MODE_ENC) begin
      bits_next = {group_bits[15:0], data_in};
      job.kind  = KIND_ENC;
      job.nres  = 3'd4;
      job.nval  = enc_cnt + 3'd1;
      unique case (enc_cnt)
        3'd1:    job.bits = {data_in, 16'h0000};
        3'd2:    job.bits = {group_bits[7:0], data_in, 8'h00};
        default: job.bits = {group_bits[15:0], data_in};
      endcase
      if (enc_cnt >= 3'd3 || last_in) begin
        push       = accept;
        bits_next  = '0;
        count_next = '0;
      end else begin
        count_next = enc_cnt[1:0];
      end
    end else begin
      bits_next = {group_bits[17:0], sextet};
      pad_next  = pad_upd;
      job.bits  = {group_bits[17:0], sextet};
      job.nval  = 3'd0;
      if (group_count == 2'd3) begin
        job.kind = KIND_DEC;
        job.nres = !last_in   ? 3'd3 :
                   pad_upd[1] ? 3'd1 :
                   pad_upd[0] ? 3'd2 : 3'd3;
        push       = accept;
        bits_next  = '0;
        count_next = '0;
        pad_next   = '0;
      end else if (last_in) begin
        job.kind   = KIND_ERR;
        job.bits   = '0;
        job.nres   = 3'd1;
        push       = accept;
        bits_next  = '0;
        count_next = '0;
        pad_next   = '0;
      end else begin
        job.kind   = KIND_DEC;
        job.nres   = 3'd3;
        count_next = group_count + 2'd1;
      end
    end
  end

  // Mode register and group state; a mode write starts a fresh group
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENC;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else if (cfg_write) begin
      mode        <= cfg_data;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else if (accept) begin
      group_bits  <= bits_next;
      group_count <= count_next;
      pad_count   <= pad_next;
    end
  end

`ifndef ASSERT_OFF
  // An error job only ever comes from the final item of a message
  assert property (@(posedge clk) disable iff (rst)
    push && job.kind == KIND_ERR |-> last_in && mode == MODE_DEC)
    else $error("error job without last item");

  // Padding is never counted in the first two places of a group
  assert property (@(posedge clk) disable iff (rst)
    group_count < 2'd3 |-> pad_count <= group_count)
    else $error("pad count ahead of group position");
`endif

endmodule

// ===== design/b64_queue.sv =====
// b64_queue: small register FIFO of closed groups between front and back end.
// Generic over width and depth; no package dependency.
module b64_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntFull);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // No write into a full queue, no read from an empty one
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue underflow");
`endif

endmodule

// ===== design/b64_back.sv =====
// b64_back: expands queued groups into result transactions, one per cycle while
// the output is not stalled, through an output register. Depends on b64_pkg.
module b64_back import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_out,
  output logic       last_out,
  output logic       error
);

  logic [1:0] idx;
  logic       load;
  logic       final_res;
  logic [5:0] sx;
  logic [7:0] byte_sel;
  logic [7:0] res_data;
  logic       res_last;
  logic       res_err;

  assign load      = head_valid && (!out_valid || out_ready);
  assign final_res = ({1'b0, idx} == head.nres - 3'd1);
  assign pop       = load && final_res;

  // Field selects for the current result
  always_comb begin
    unique case (idx)
      2'd0:    sx = head.bits[23:18];
      2'd1:    sx = head.bits[17:12];
      2'd2:    sx = head.bits[11:6];
      default: sx = head.bits[5:0];
    endcase
    unique case (idx)
      2'd0:    byte_sel = head.bits[23:16];
      2'd1:    byte_sel = head.bits[15:8];
      default: byte_sel = head.bits[7:0];
    endcase
  end

  // Result value by job kind
  always_comb begin
    unique case (head.kind)
      KIND_ENC: begin
        res_data = ({1'b0, idx} < head.nval) ? b64_char(sx) : CHAR_PAD;
        res_last = head.last && final_res;
        res_err  = 1'b0;
      end
      KIND_DEC: begin
        res_data = byte_sel;
        res_last = head.last && final_res;
        res_err  = 1'b0;
      end
      default: begin
        res_data = 8'h00;
        res_last = 1'b1;
        res_err  = 1'b1;
      end
    endcase
  end

  // Result index within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= final_res ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_out <= res_data;
      last_out <= res_last;
      error    <= res_err;
    end
  end

`ifndef ASSERT_OFF
  // The index never runs past the job's result count
  assert property (@(posedge clk) disable iff (rst)
    head_valid |-> {1'b0, idx} < head.nres)
    else $error("result index beyond job");

  // An error result is always a zero final result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last_out && data_out == 8'h00)
    else $error("malformed error result");
`endif

endmodule

// ===== design/base64_codec.sv =====
// base64_codec: streaming Base64 encoder/decoder, top level.
// Depends on b64_pkg, b64_front, b64_queue, b64_back.
//
// Usage:
//   Input channel  in_valid/in_ready carries data_in and last_in; output channel
//   out_valid/out_ready carries data_out, last_out and error. cfg_write loads
//   cfg_data into the mode bit (0 encode, 1 decode) and restarts group
//   gathering; write it only while the codec is idle.
//   Encode: every three bytes, or a shorter group ending in last_in, give four
//   characters, padded with '='. Decode: every four characters give up to three
//   bytes; a message ending in an incomplete group gives one result with error.
// Path: an accepted transaction that closes a group pushes the group into the
//   queue, and its first result is then loaded into the output register.
// Throughput: the back end issues one result per cycle while out_ready does not
//   stall it; encode input is held back by the four characters that each group
//   of three bytes gives, and decode takes one character per cycle. A queue of
//   QUEUE_DEPTH closed groups lets input continue while the back end drains.
// Reset: rst clears mode to encode, the group state, the queue and out_valid.
// Stall: while out_ready is low the output register holds; the queue fills
//   and then in_ready drops.
module base64_codec import b64_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_out,
  output logic       last_out,
  output logic       error
);

  logic                queue_full;
  logic                push;
  job_t                job;
  logic                pop;
  logic                head_valid;
  logic [JobWidth-1:0] head_bits;
  job_t                head;

  assign head = job_t'(head_bits);

  b64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_in    (data_in),
    .last_in    (last_in),
    .queue_full (queue_full),
    .push       (push),
    .job        (job)
  );

  b64_queue #(
    .WIDTH (JobWidth),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      (job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head_bits)
  );

  b64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_out   (data_out),
    .last_out   (last_out),
    .error      (error)
  );

endmodule
